// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

  // Widths fixed by the data format
  localparam int DATA_W     = 8;
  localparam int ADDR_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int KEY_LEN_W  = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int KEY_BYTES_PER_REG = 8;

  localparam int MAX_KEY_BYTES_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD_I,
    ST_KS_ADD,
    ST_KS_WR_I,
    ST_KS_WR_J,
    ST_PR_RD_I,
    ST_PR_ADD,
    ST_PR_WR_I,
    ST_PR_WR_J,
    ST_PR_RD_K,
    ST_PR_OUT
  } state_t;

  // One write and one read port on the permutation memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

// ===== rtl/rc4_perm_ram.sv =====
module rc4_perm_ram (
  input  logic                      clk,
  input  rc4_pkg::ram_req_t         req,
  output logic [rc4_pkg::DATA_W-1:0] rd_data
);

  logic [rc4_pkg::DATA_W-1:0] mem [rc4_pkg::PERM_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port, holds its value while not enabled
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/rc4_core.sv =====
module rc4_core #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_valid,
  output logic                                   s_ready,
  input  logic [rc4_pkg::DATA_W-1:0]             s_data,
  input  logic                                   s_restart,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic [rc4_pkg::DATA_W-1:0]             res_data,
  input  logic [MAX_KEY_BYTES-1:0][rc4_pkg::DATA_W-1:0] key_bytes,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]          key_len,
  output rc4_pkg::ram_req_t                      ram_req,
  input  logic [rc4_pkg::DATA_W-1:0]             ram_rd_data
);

  localparam int DW     = rc4_pkg::DATA_W;
  localparam int AW     = rc4_pkg::ADDR_W;
  localparam int KLW    = rc4_pkg::KEY_LEN_W;
  localparam int KPOS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(rc4_pkg::PERM_DEPTH - 1);

  rc4_pkg::state_t state, state_next;

  logic [AW-1:0]     i;
  logic [AW-1:0]     j;
  logic [DW-1:0]     si;
  logic [DW-1:0]     sj;
  logic [DW-1:0]     data;
  logic [KPOS_W-1:0] kpos;
  logic              sched_done;

  logic [DW-1:0] add_a, add_b, add_c, add_sum;
  logic          i_last, kpos_last, restart;

  assign i_last    = (i == LAST_IDX);
  assign kpos_last = ((KLW'(kpos) + KLW'(1)) == key_len);
  assign restart   = s_restart || !sched_done;

  // Shared 8-bit adder: key schedule j, keystream j and keystream index
  always_comb begin
    add_a = j;
    add_b = ram_rd_data;
    add_c = '0;
    case (state)
      rc4_pkg::ST_KS_ADD: add_c = key_bytes[kpos];
      rc4_pkg::ST_PR_RD_K: begin
        add_a = si;
        add_b = sj;
      end
      default: ;
    endcase
  end
  assign add_sum = add_a + add_b + add_c;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rc4_pkg::ST_IDLE: begin
        if (s_valid) begin
          state_next = restart ? rc4_pkg::ST_FILL : rc4_pkg::ST_PR_RD_I;
        end
      end
      rc4_pkg::ST_FILL:    if (i_last) state_next = rc4_pkg::ST_KS_RD_I;
      rc4_pkg::ST_KS_RD_I: state_next = rc4_pkg::ST_KS_ADD;
      rc4_pkg::ST_KS_ADD:  state_next = rc4_pkg::ST_KS_WR_I;
      rc4_pkg::ST_KS_WR_I: state_next = rc4_pkg::ST_KS_WR_J;
      rc4_pkg::ST_KS_WR_J: begin
        state_next = i_last ? rc4_pkg::ST_PR_RD_I : rc4_pkg::ST_KS_RD_I;
      end
      rc4_pkg::ST_PR_RD_I: state_next = rc4_pkg::ST_PR_ADD;
      rc4_pkg::ST_PR_ADD:  state_next = rc4_pkg::ST_PR_WR_I;
      rc4_pkg::ST_PR_WR_I: state_next = rc4_pkg::ST_PR_WR_J;
      rc4_pkg::ST_PR_WR_J: state_next = rc4_pkg::ST_PR_RD_K;
      rc4_pkg::ST_PR_RD_K: state_next = rc4_pkg::ST_PR_OUT;
      rc4_pkg::ST_PR_OUT:  if (res_ready) state_next = rc4_pkg::ST_IDLE;
      default:             state_next = rc4_pkg::ST_IDLE;
    endcase
  end

  // Outputs and memory port
  always_comb begin
    ram_req   = '0;
    s_ready   = 1'b0;
    res_valid = 1'b0;
    case (state)
      rc4_pkg::ST_IDLE: s_ready = 1'b1;
      rc4_pkg::ST_FILL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = i;
        ram_req.wdata = i;
      end
      rc4_pkg::ST_KS_RD_I, rc4_pkg::ST_PR_RD_I: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = i;
      end
      rc4_pkg::ST_KS_ADD, rc4_pkg::ST_PR_ADD, rc4_pkg::ST_PR_RD_K: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = add_sum;
      end
      rc4_pkg::ST_KS_WR_I, rc4_pkg::ST_PR_WR_I: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = i;
        ram_req.wdata = ram_rd_data;
      end
      rc4_pkg::ST_KS_WR_J, rc4_pkg::ST_PR_WR_J: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = j;
        ram_req.wdata = si;
      end
      rc4_pkg::ST_PR_OUT: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res_data = data ^ ram_rd_data;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rc4_pkg::ST_IDLE;
      i          <= '0;
      j          <= '0;
      kpos       <= '0;
      sched_done <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        rc4_pkg::ST_IDLE: begin
          if (s_valid) begin
            i <= restart ? '0 : i + AW'(1);
          end
        end
        rc4_pkg::ST_FILL: begin
          i    <= i + AW'(1);
          j    <= '0;
          kpos <= '0;
        end
        rc4_pkg::ST_KS_ADD, rc4_pkg::ST_PR_ADD: j <= add_sum;
        rc4_pkg::ST_KS_WR_J: begin
          if (i_last) begin
            // schedule finished: indices cleared, then the byte's own step
            i          <= AW'(1);
            j          <= '0;
            sched_done <= 1'b1;
          end else begin
            i    <= i + AW'(1);
            kpos <= kpos_last ? '0 : kpos + KPOS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == rc4_pkg::ST_IDLE && s_valid) begin
      data <= s_data;
    end
    if (state == rc4_pkg::ST_KS_ADD || state == rc4_pkg::ST_PR_ADD) begin
      si <= ram_rd_data;
    end
    if (state == rc4_pkg::ST_PR_WR_I) begin
      sj <= ram_rd_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == rc4_pkg::ST_IDLE) |-> !ram_req.we)
    else $error("permutation written while idle");

  a_sched_end: assert property (@(posedge clk) disable iff (rst)
    (state == rc4_pkg::ST_KS_WR_J && i_last) |=> (i == AW'(1) && j == '0 && sched_done))
    else $error("indices not reset after key schedule");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("pending result changed before transfer");

  a_byte_needs_sched: assert property (@(posedge clk) disable iff (rst)
    (state == rc4_pkg::ST_PR_RD_I) |-> sched_done)
    else $error("keystream step without key schedule");
`endif

endmodule

// ===== rtl/rc4_stream_cipher_unit.sv =====
// Bytes are taken one at a time: a new input byte is accepted only once the
//   previous result has passed to the output register; the pace is set by the
//   dependent reads and the swap writes to the permutation memory. A key schedule
//   (first byte after reset or tuser set) runs first: 256 fills, then 256 swaps.
// Reset: synchronous; clears the sequencer, indices, key (length 1) and
//   output valid. The permutation is not cleared; the schedule fills it.
module rc4_stream_cipher_unit #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] data_in
  input  logic                               s_axis_tuser,  // [0] new_message
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata   // [7:0] data_out
);

  localparam int DW    = rc4_pkg::DATA_W;
  localparam int KLW   = rc4_pkg::KEY_LEN_W;
  localparam int BPR   = rc4_pkg::KEY_BYTES_PER_REG;
  localparam int LOW_N = (MAX_KEY_BYTES < BPR) ? MAX_KEY_BYTES : BPR;

  logic [MAX_KEY_BYTES-1:0][DW-1:0] key_bytes;
  logic [KLW-1:0]                   key_length;
  logic [KLW-1:0]                   key_len_eff;

  rc4_pkg::ram_req_t ram_req;
  logic [DW-1:0]     ram_rd_data;
  logic              res_valid, res_ready;
  logic [DW-1:0]     res_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes  <= '0;
      key_length <= KLW'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rc4_pkg::REG_KEY_LOW: begin
          for (int b = 0; b < LOW_N; b++) begin
            key_bytes[b] <= cfg_data[DW*b +: DW];
          end
        end
        rc4_pkg::REG_KEY_HIGH: begin
          for (int b = BPR; b < MAX_KEY_BYTES; b++) begin
            key_bytes[b] <= cfg_data[DW*(b-BPR) +: DW];
          end
        end
        rc4_pkg::REG_KEY_LENGTH: key_length <= cfg_data[KLW-1:0];
        default: ;
      endcase
    end
  end

  // Zero length means one byte; longer than supported saturates
  always_comb begin
    if (key_length == '0) begin
      key_len_eff = KLW'(1);
    end else if (key_length > KLW'(MAX_KEY_BYTES)) begin
      key_len_eff = KLW'(MAX_KEY_BYTES);
    end else begin
      key_len_eff = key_length;
    end
  end

  rc4_core #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .s_data      (s_axis_tdata),
    .s_restart   (s_axis_tuser),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_data    (res_data),
    .key_bytes   (key_bytes),
    .key_len     (key_len_eff),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  rc4_perm_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  // Output register: loads when empty or when the held byte transfers
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= res_data;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int MAX_KEY     = rc4_pkg::MAX_KEY_BYTES_DEF;
  // Index past the register list; writes to it must be dropped
  localparam logic [rc4_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic [rc4_pkg::DATA_W-1:0] byte_t;

  // Keystream predictor plus the queue of output bytes still owed by the block
  class rc4_keystream_model;
    byte_t          perm [rc4_pkg::PERM_DEPTH];
    byte_t          idx_i;
    byte_t          idx_j;
    bit             sched_done;
    logic [63:0]    key_lo;
    logic [63:0]    key_hi;
    logic [4:0]     key_len;
    byte_t          expected_bytes[$];
    int             error_count;

    function new();
      key_lo = '0;
      key_hi = '0;
      key_len = 5'd1;
      idx_i = '0;
      idx_j = '0;
      sched_done = 1'b0;
      error_count = 0;
      foreach (perm[n]) perm[n] = '0;
    endfunction

    function void write_reg(logic [rc4_pkg::CFG_IDX_W-1:0] idx,
                            logic [rc4_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        rc4_pkg::REG_KEY_LOW:    key_lo = val;
        rc4_pkg::REG_KEY_HIGH:   key_hi = val;
        rc4_pkg::REG_KEY_LENGTH: key_len = val[rc4_pkg::KEY_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // One input transfer: reschedule if needed, then one keystream step
    function void note_byte_in(byte_t din, bit restart);
      int    len;
      int    p;
      byte_t jj;
      byte_t tmp;
      byte_t kb;
      byte_t sum;
      if (restart || !sched_done) begin
        len = key_len;
        if (len == 0) len = 1;
        if (len > MAX_KEY) len = MAX_KEY;
        for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) perm[n] = byte_t'(n);
        jj = '0;
        for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
          p = n % len;
          kb = (p < rc4_pkg::KEY_BYTES_PER_REG) ? key_lo[8*p +: 8] : key_hi[8*(p-8) +: 8];
          jj = jj + perm[n] + kb;
          tmp = perm[n];
          perm[n] = perm[jj];
          perm[jj] = tmp;
        end
        idx_i = '0;
        idx_j = '0;
        sched_done = 1'b1;
      end
      idx_i = idx_i + 1'b1;
      idx_j = idx_j + perm[idx_i];
      tmp = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = tmp;
      sum = perm[idx_i] + perm[idx_j];
      expected_bytes.push_back(din ^ perm[sum]);
    endfunction

    function void check_byte_out(byte_t dout);
      byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("data_out: unexpected output transfer, actual %02h", dout);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (dout !== want) begin
          $error("data_out mismatch: expected %02h, actual %02h", want, dout);
          error_count++;
        end
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr_en = 1'b0;
  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;   // [7:0] data_in
  logic                           s_axis_tuser = 1'b0; // [0] new_message
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;        // [7:0] data_out

  rc4_keystream_model model;
  int send_idle_pct = 29;
  int recv_idle_pct = 85;
  int cycle_count = 0;

  rc4_stream_cipher_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Output transfers
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) model.check_byte_out(m_axis_tdata);
  end

  // All tasks start and end at a falling edge
  task automatic send_byte(byte_t din, bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= din;
    s_axis_tuser  <= restart;
    do @(posedge clk); while (!s_axis_tready);
    model.note_byte_in(din, restart);
    @(negedge clk);
  endtask

  // A raised valid always has a byte in flight, so the loop waits at least once
  task automatic wait_drained();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
  endtask

  // Only called once the block is drained
  task automatic write_reg(logic [rc4_pkg::CFG_IDX_W-1:0] idx,
                           logic [rc4_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    model.write_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [rc4_pkg::CFG_DATA_W-1:0] pick_key_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Length field with random upper bits, biased towards the limits
  function automatic logic [rc4_pkg::CFG_DATA_W-1:0] pick_key_len();
    logic [rc4_pkg::CFG_DATA_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0:       v[4:0] = 5'd1;
      1:       v[4:0] = 5'd16;
      2:       v[4:0] = 5'($urandom_range(31));
      default: v[4:0] = 5'($urandom_range(1, 16));
    endcase
    return v;
  endfunction

  task automatic random_config();
    int n_writes;
    logic [rc4_pkg::CFG_IDX_W-1:0] idx;
    n_writes = $urandom_range(1, 3);
    wait_drained();
    repeat (n_writes) begin
      idx = rc4_pkg::CFG_IDX_W'($urandom_range(3));
      case (idx)
        rc4_pkg::REG_KEY_LOW, rc4_pkg::REG_KEY_HIGH: write_reg(idx, pick_key_word());
        rc4_pkg::REG_KEY_LENGTH:                     write_reg(idx, pick_key_len());
        default: write_reg(REG_UNUSED, {$urandom, $urandom});
      endcase
    end
  endtask

  // Messages of random length; mostly opened with a restart, sometimes carried on
  task automatic run_messages(int n_items);
    int sent;
    int msg_len;
    bit restart;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) random_config();
      msg_len = $urandom_range(1, 48);
      restart = ($urandom_range(4) != 0);
      for (int k = 0; k < msg_len; k++) begin
        send_byte(byte_t'($urandom), (k == 0) ? restart : ($urandom_range(63) == 0));
        sent++;
      end
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  initial begin
    model = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // First bytes after reset schedule on the reset key without a restart flag
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    wait_drained();

    // Full-length all-ones key
    write_reg(rc4_pkg::REG_KEY_LOW, '1);
    write_reg(rc4_pkg::REG_KEY_HIGH, '1);
    write_reg(rc4_pkg::REG_KEY_LENGTH, 64'd16);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    wait_drained();

    // Zero length behaves as one byte
    write_reg(rc4_pkg::REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
    write_reg(rc4_pkg::REG_KEY_HIGH, 64'hFEDC_BA98_7654_3210);
    write_reg(rc4_pkg::REG_KEY_LENGTH, 64'd0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b0);
    wait_drained();

    // Oversized lengths saturate
    write_reg(rc4_pkg::REG_KEY_LENGTH, 64'd31);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hFE, 1'b0);
    wait_drained();
    write_reg(rc4_pkg::REG_KEY_LENGTH, {59'h5A5A_5A5A_5A5A_5A5, 5'd17});
    send_byte(8'h10, 1'b1);
    wait_drained();

    // Write past the register list is dropped
    write_reg(REG_UNUSED, '1);
    send_byte(8'h33, 1'b1);
    wait_drained();

    // Key change mid-message only counts from the next restart
    write_reg(rc4_pkg::REG_KEY_LOW, '0);
    write_reg(rc4_pkg::REG_KEY_LENGTH, 64'd1);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    wait_drained();

    // Random traffic under three idling patterns
    run_messages(640);
    send_idle_pct = 85;
    recv_idle_pct = 29;
    run_messages(630);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_messages(630);

    wait_drained();
    repeat (20) @(negedge clk);
    if (model.error_count == 0 && model.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rc4_pkg.sv
rtl/rc4_perm_ram.sv
rtl/rc4_core.sv
rtl/rc4_stream_cipher_unit.sv
tb/tb_top.sv
